// ===== hw/rtl/bpsp_pkg.sv =====
package bpsp_pkg;

  localparam int COORD_BITS = 16;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4D;
  localparam logic [31:0] OFS_FIRST  = 32'd10;
  localparam logic [31:0] WID_FIRST  = 32'd18;
  localparam logic [31:0] HGT_FIRST  = 32'd22;
  localparam logic [31:0] HEADER_END = 32'd26;
  localparam logic [31:0] FIELD_LAST = 32'd3;

  localparam logic [1:0] BIP_BLUE  = 2'd0;
  localparam logic [1:0] BIP_GREEN = 2'd1;
  localparam logic [1:0] BIP_RED   = 2'd2;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_BAD_SIG = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_IDLE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
    logic                  final_pixel;
  } out_item_t;

  function automatic logic [31:0] ins_byte(input logic [31:0] cur, input logic [7:0] b,
                                           input logic [1:0] lane);
    logic [31:0] ext;
    ext = {24'd0, b};
    return cur | (ext << {lane, 3'b000});
  endfunction

  function automatic logic [COORD_BITS-1:0] dim_sat(input logic [31:0] cand);
    logic [31:0] upper;
    upper = cand >> COORD_BITS;
    if (upper != 32'd0) begin
      return {COORD_BITS{1'b1}};
    end
    return cand[COORD_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/bmp_pixel_stream_parser.sv =====
// Channel   Ports                         Moves
// input     in_push, in_full, in_item     one file byte, first_byte restarts parsing
// result    out_pop, out_empty, out_item  one pixel or one bad-signature item
//
// One byte is taken every cycle while in_full is low; each byte yields zero or one item.
// A pixel item is queued as its last color byte is taken; out_item shows the oldest item.
// in_full rises only when the two-entry result queue is full, so a stalled consumer
// stalls the producer after two waiting items; a pop frees a slot for the next cycle.
// Reset (rst_n low, synchronous) returns the parser to the header phase at byte zero.
module bmp_pixel_stream_parser import bpsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic      acc;
  logic      res_valid;
  out_item_t res;

  assign acc = in_push && !in_full;

  bpsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  bpsp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_item (res),
    .rd_en   (out_pop),
    .rd_item (out_item),
    .full    (in_full),
    .empty   (out_empty)
  );

endmodule

// ===== hw/rtl/bpsp_front.sv =====
module bpsp_front import bpsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  phase_t                phase_r, phase_nxt;
  logic [31:0]           pos_r, pos_nxt;
  logic [31:0]           offset_r, offset_nxt;
  logic [COORD_BITS-1:0] width_r, width_nxt;
  logic [COORD_BITS-1:0] height_r, height_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [1:0]            bip_r, bip_nxt;
  logic [15:0]           held_r, held_nxt;
  logic [1:0]            pad_r, pad_nxt;

  logic                  restart;
  logic [7:0]            b;
  phase_t                phase_e;
  logic [31:0]           pos_e, offset_e, pos_inc, offset_new;
  logic [COORD_BITS-1:0] width_e, height_e, width_new, height_new;
  logic                  bad_sig, hdr_done, dims_zero;
  logic                  in_ofs, in_wid, in_hgt;
  logic                  emit, col_wrap, last_pix;
  logic [COORD_BITS:0]   col_inc, row_inc;

  assign restart  = item.first_byte;
  assign b        = item.data_byte;
  assign phase_e  = restart ? PH_HEADER : phase_r;
  assign pos_e    = restart ? 32'd0 : pos_r;
  assign offset_e = restart ? 32'd0 : offset_r;
  assign width_e  = restart ? '0 : width_r;
  assign height_e = restart ? '0 : height_r;

  assign pos_inc = (pos_e == 32'hFFFF_FFFF) ? pos_e : pos_e + 32'd1;
  assign bad_sig = ((pos_e == 32'd0) && (b != SIG_B)) || ((pos_e == 32'd1) && (b != SIG_M));

  assign in_ofs = (pos_e >= OFS_FIRST) && (pos_e <= OFS_FIRST + FIELD_LAST);
  assign in_wid = (pos_e >= WID_FIRST) && (pos_e <= WID_FIRST + FIELD_LAST);
  assign in_hgt = (pos_e >= HGT_FIRST) && (pos_e <= HGT_FIRST + FIELD_LAST);

  assign offset_new = in_ofs ? ins_byte(offset_e, b, pos_e[1:0] - OFS_FIRST[1:0]) : offset_e;
  assign width_new  = in_wid ?
      dim_sat(ins_byte({{(32-COORD_BITS){1'b0}}, width_e}, b, pos_e[1:0] - WID_FIRST[1:0])) :
      width_e;
  assign height_new = in_hgt ?
      dim_sat(ins_byte({{(32-COORD_BITS){1'b0}}, height_e}, b, pos_e[1:0] - HGT_FIRST[1:0])) :
      height_e;

  assign hdr_done  = (pos_inc >= HEADER_END) && (pos_inc >= offset_new);
  assign dims_zero = (width_new == '0) || (height_new == '0);

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign emit     = (phase_e == PH_PIXELS) && (pad_r == 2'd0) && (bip_r == BIP_RED);
  assign col_wrap = col_inc >= {1'b0, width_r};
  assign last_pix = col_wrap && (row_inc >= {1'b0, height_r});

  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (phase_e)
        PH_HEADER: begin
          if (bad_sig) begin
            phase_nxt = PH_IDLE;
          end else if (hdr_done) begin
            phase_nxt = dims_zero ? PH_IDLE : PH_PIXELS;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_PIXELS: begin
          phase_nxt = (emit && last_pix) ? PH_IDLE : PH_PIXELS;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    bip_nxt    = bip_r;
    held_nxt   = held_r;
    pad_nxt    = pad_r;
    res_valid  = 1'b0;
    res        = '0;
    if (acc) begin
      pos_nxt    = pos_e;
      offset_nxt = offset_e;
      width_nxt  = width_e;
      height_nxt = height_e;
      case (phase_e)
        PH_HEADER: begin
          pos_nxt = pos_inc;
          if (bad_sig) begin
            res_valid = 1'b1;
            res.kind  = KIND_BAD_SIG;
          end else begin
            offset_nxt = offset_new;
            width_nxt  = width_new;
            height_nxt = height_new;
            if (hdr_done) begin
              col_nxt  = '0;
              row_nxt  = '0;
              bip_nxt  = BIP_BLUE;
              held_nxt = '0;
              pad_nxt  = 2'd0;
            end
          end
        end
        PH_PIXELS: begin
          if (pad_r != 2'd0) begin
            pad_nxt = pad_r - 2'd1;
          end else if (bip_r == BIP_BLUE) begin
            held_nxt[7:0] = b;
            bip_nxt       = BIP_GREEN;
          end else if (bip_r == BIP_GREEN) begin
            held_nxt[15:8] = b;
            bip_nxt        = BIP_RED;
          end else begin
            bip_nxt         = BIP_BLUE;
            res_valid       = 1'b1;
            res.kind        = KIND_PIXEL;
            res.x_coord     = width_r - 1'b1 - col_r;
            res.y_coord     = height_r - 1'b1 - row_r;
            res.blue        = held_r[7:0];
            res.green       = held_r[15:8];
            res.red         = b;
            res.final_pixel = last_pix;
            col_nxt         = col_inc[COORD_BITS-1:0];
            if (col_wrap) begin
              col_nxt = '0;
              row_nxt = row_inc[COORD_BITS-1:0];
              pad_nxt = last_pix ? 2'd0 : width_r[1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      bip_r    <= BIP_BLUE;
      held_r   <= '0;
      pad_r    <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      bip_r    <= bip_nxt;
      held_r   <= held_nxt;
      pad_r    <= pad_nxt;
    end
  end

endmodule

// ===== hw/rtl/bpsp_queue.sv =====
module bpsp_queue import bpsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_item_t wr_item,
  input  logic      rd_en,
  output out_item_t rd_item,
  output logic      full,
  output logic      empty
);

  out_item_t            slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_wr, do_rd;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule
